// File: rtl/tskf_pkg.sv
// Shared types, operand codes, helpers and the microprogram of the two-state
// Kalman filter. No dependencies.
`default_nettype none
package tskf_pkg;

	localparam int RF_DEPTH = 39;
	localparam int UCODE_LEN = 106;
	localparam logic [6:0] PC_FIRST = 7'd0;
	localparam logic [6:0] PC_MAIN = 7'd7;
	localparam logic [6:0] PC_SING = 7'd99;

	typedef logic [5:0] opnd_t;

	localparam opnd_t V_X0 = 6'd0, V_X1 = 6'd1;
	localparam opnd_t V_P0 = 6'd2, V_P1 = 6'd3, V_P2 = 6'd4, V_P3 = 6'd5;
	localparam opnd_t V_XP0 = 6'd6, V_XP1 = 6'd7;
	localparam opnd_t V_AP0 = 6'd8, V_AP1 = 6'd9, V_AP2 = 6'd10, V_AP3 = 6'd11;
	localparam opnd_t V_PP0 = 6'd12, V_PP1 = 6'd13, V_PP2 = 6'd14, V_PP3 = 6'd15;
	localparam opnd_t V_HP0 = 6'd16, V_HP1 = 6'd17, V_HP2 = 6'd18, V_HP3 = 6'd19;
	localparam opnd_t V_S0 = 6'd20, V_S1 = 6'd21, V_S2 = 6'd22, V_S3 = 6'd23;
	localparam opnd_t V_D0 = 6'd24, V_D1 = 6'd25, V_D2 = 6'd26, V_D3 = 6'd27;
	localparam opnd_t V_K0 = 6'd28, V_K1 = 6'd29, V_K2 = 6'd30, V_K3 = 6'd31;
	localparam opnd_t V_E0 = 6'd32, V_E1 = 6'd33, V_HX = 6'd34;
	localparam opnd_t V_G0 = 6'd35, V_G1 = 6'd36, V_G2 = 6'd37, V_G3 = 6'd38;
	localparam opnd_t V_Z0 = 6'd39, V_Z1 = 6'd40, V_U = 6'd41;
	localparam opnd_t V_A0 = 6'd42, V_A1 = 6'd43, V_A2 = 6'd44, V_A3 = 6'd45;
	localparam opnd_t V_B0 = 6'd46, V_B1 = 6'd47;
	localparam opnd_t V_H0 = 6'd48, V_H1 = 6'd49, V_H2 = 6'd50, V_H3 = 6'd51;
	localparam opnd_t V_Q0 = 6'd52, V_Q1 = 6'd53, V_Q2 = 6'd54, V_Q3 = 6'd55;
	localparam opnd_t V_R0 = 6'd56, V_R1 = 6'd57, V_R2 = 6'd58, V_R3 = 6'd59;
	localparam opnd_t V_ONE = 6'd60, V_ZERO = 6'd61, V_ONEX = 6'd62, V_NONE = 6'd63;

	localparam opnd_t DST_DET = 6'd62;
	localparam opnd_t DST_NUM = 6'd63;

	localparam logic [2:0] REG_A = 3'd0;
	localparam logic [2:0] REG_B = 3'd1;
	localparam logic [2:0] REG_H = 3'd2;
	localparam logic [2:0] REG_Q = 3'd3;
	localparam logic [2:0] REG_R = 3'd4;

	typedef enum logic [1:0] {U_MAC, U_DIV, U_CHK, U_END} uop_t;
	typedef enum logic [1:0] {SH_0, SH_12, SH_16} sh_t;

	typedef struct packed {
		uop_t op;
		opnd_t a;
		opnd_t b;
		sh_t sh;
		opnd_t ini;
		logic sub;
		logic last;
		opnd_t dst;
	} uinst_t;

	function automatic logic signed [31:0] ent(input logic [63:0] r, input logic [1:0] i);
		logic [15:0] f;
		f = r[16*i +: 16];
		return {{16{f[15]}}, f};
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (v < -66'sh0_8000_0000) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic uinst_t m(input opnd_t a, input opnd_t b, input sh_t sh,
		input opnd_t ini, input logic sub, input logic last, input opnd_t dst);
		return '{op: U_MAC, a: a, b: b, sh: sh, ini: ini, sub: sub, last: last, dst: dst};
	endfunction

	function automatic uinst_t dv(input opnd_t dst);
		return '{op: U_DIV, a: V_ZERO, b: V_ZERO, sh: SH_0, ini: V_NONE, sub: 1'b0,
			last: 1'b0, dst: dst};
	endfunction

	function automatic uinst_t ck();
		return '{op: U_CHK, a: V_ZERO, b: V_ZERO, sh: SH_0, ini: V_NONE, sub: 1'b0,
			last: 1'b0, dst: V_X0};
	endfunction

	function automatic uinst_t fin();
		return '{op: U_END, a: V_X0, b: V_X1, sh: SH_0, ini: V_NONE, sub: 1'b0,
			last: 1'b0, dst: V_X0};
	endfunction

	localparam uinst_t UCODE [UCODE_LEN] = '{
		// first item
		m(V_Z0, V_ONE, SH_0, V_ZERO, 1'b0, 1'b1, V_X0),
		m(V_Z1, V_ONE, SH_0, V_ZERO, 1'b0, 1'b1, V_X1),
		m(V_ZERO, V_ZERO, SH_0, V_Q0, 1'b0, 1'b1, V_P0),
		m(V_ZERO, V_ZERO, SH_0, V_Q1, 1'b0, 1'b1, V_P1),
		m(V_ZERO, V_ZERO, SH_0, V_Q2, 1'b0, 1'b1, V_P2),
		m(V_ZERO, V_ZERO, SH_0, V_Q3, 1'b0, 1'b1, V_P3),
		fin(),
		// predicted state
		m(V_B0, V_U, SH_12, V_ZERO, 1'b0, 1'b0, V_XP0),
		m(V_A0, V_X0, SH_12, V_NONE, 1'b0, 1'b0, V_XP0),
		m(V_A1, V_X1, SH_12, V_NONE, 1'b0, 1'b1, V_XP0),
		m(V_B1, V_U, SH_12, V_ZERO, 1'b0, 1'b0, V_XP1),
		m(V_A2, V_X0, SH_12, V_NONE, 1'b0, 1'b0, V_XP1),
		m(V_A3, V_X1, SH_12, V_NONE, 1'b0, 1'b1, V_XP1),
		// A P
		m(V_A0, V_P0, SH_12, V_ZERO, 1'b0, 1'b0, V_AP0),
		m(V_A1, V_P2, SH_12, V_NONE, 1'b0, 1'b1, V_AP0),
		m(V_A0, V_P1, SH_12, V_ZERO, 1'b0, 1'b0, V_AP1),
		m(V_A1, V_P3, SH_12, V_NONE, 1'b0, 1'b1, V_AP1),
		m(V_A2, V_P0, SH_12, V_ZERO, 1'b0, 1'b0, V_AP2),
		m(V_A3, V_P2, SH_12, V_NONE, 1'b0, 1'b1, V_AP2),
		m(V_A2, V_P1, SH_12, V_ZERO, 1'b0, 1'b0, V_AP3),
		m(V_A3, V_P3, SH_12, V_NONE, 1'b0, 1'b1, V_AP3),
		// A P A^T + Q
		m(V_AP0, V_A0, SH_12, V_Q0, 1'b0, 1'b0, V_PP0),
		m(V_AP1, V_A1, SH_12, V_NONE, 1'b0, 1'b1, V_PP0),
		m(V_AP0, V_A2, SH_12, V_Q1, 1'b0, 1'b0, V_PP1),
		m(V_AP1, V_A3, SH_12, V_NONE, 1'b0, 1'b1, V_PP1),
		m(V_AP2, V_A0, SH_12, V_Q2, 1'b0, 1'b0, V_PP2),
		m(V_AP3, V_A1, SH_12, V_NONE, 1'b0, 1'b1, V_PP2),
		m(V_AP2, V_A2, SH_12, V_Q3, 1'b0, 1'b0, V_PP3),
		m(V_AP3, V_A3, SH_12, V_NONE, 1'b0, 1'b1, V_PP3),
		// H P'
		m(V_H0, V_PP0, SH_12, V_ZERO, 1'b0, 1'b0, V_HP0),
		m(V_H1, V_PP2, SH_12, V_NONE, 1'b0, 1'b1, V_HP0),
		m(V_H0, V_PP1, SH_12, V_ZERO, 1'b0, 1'b0, V_HP1),
		m(V_H1, V_PP3, SH_12, V_NONE, 1'b0, 1'b1, V_HP1),
		m(V_H2, V_PP0, SH_12, V_ZERO, 1'b0, 1'b0, V_HP2),
		m(V_H3, V_PP2, SH_12, V_NONE, 1'b0, 1'b1, V_HP2),
		m(V_H2, V_PP1, SH_12, V_ZERO, 1'b0, 1'b0, V_HP3),
		m(V_H3, V_PP3, SH_12, V_NONE, 1'b0, 1'b1, V_HP3),
		// innovation covariance
		m(V_HP0, V_H0, SH_12, V_R0, 1'b0, 1'b0, V_S0),
		m(V_HP1, V_H1, SH_12, V_NONE, 1'b0, 1'b1, V_S0),
		m(V_HP0, V_H2, SH_12, V_R1, 1'b0, 1'b0, V_S1),
		m(V_HP1, V_H3, SH_12, V_NONE, 1'b0, 1'b1, V_S1),
		m(V_HP2, V_H0, SH_12, V_R2, 1'b0, 1'b0, V_S2),
		m(V_HP3, V_H1, SH_12, V_NONE, 1'b0, 1'b1, V_S2),
		m(V_HP2, V_H2, SH_12, V_R3, 1'b0, 1'b0, V_S3),
		m(V_HP3, V_H3, SH_12, V_NONE, 1'b0, 1'b1, V_S3),
		// determinant
		m(V_S0, V_S3, SH_0, V_ZERO, 1'b0, 1'b0, DST_DET),
		m(V_S1, V_S2, SH_0, V_NONE, 1'b1, 1'b1, DST_DET),
		ck(),
		// P' H^T
		m(V_PP0, V_H0, SH_12, V_ZERO, 1'b0, 1'b0, V_D0),
		m(V_PP1, V_H1, SH_12, V_NONE, 1'b0, 1'b1, V_D0),
		m(V_PP0, V_H2, SH_12, V_ZERO, 1'b0, 1'b0, V_D1),
		m(V_PP1, V_H3, SH_12, V_NONE, 1'b0, 1'b1, V_D1),
		m(V_PP2, V_H0, SH_12, V_ZERO, 1'b0, 1'b0, V_D2),
		m(V_PP3, V_H1, SH_12, V_NONE, 1'b0, 1'b1, V_D2),
		m(V_PP2, V_H2, SH_12, V_ZERO, 1'b0, 1'b0, V_D3),
		m(V_PP3, V_H3, SH_12, V_NONE, 1'b0, 1'b1, V_D3),
		// gain
		m(V_D0, V_S3, SH_0, V_ZERO, 1'b0, 1'b0, DST_NUM),
		m(V_D1, V_S2, SH_0, V_NONE, 1'b1, 1'b1, DST_NUM),
		dv(V_K0),
		m(V_D0, V_S1, SH_0, V_ZERO, 1'b1, 1'b0, DST_NUM),
		m(V_D1, V_S0, SH_0, V_NONE, 1'b0, 1'b1, DST_NUM),
		dv(V_K1),
		m(V_D2, V_S3, SH_0, V_ZERO, 1'b0, 1'b0, DST_NUM),
		m(V_D3, V_S2, SH_0, V_NONE, 1'b1, 1'b1, DST_NUM),
		dv(V_K2),
		m(V_D2, V_S1, SH_0, V_ZERO, 1'b1, 1'b0, DST_NUM),
		m(V_D3, V_S0, SH_0, V_NONE, 1'b0, 1'b1, DST_NUM),
		dv(V_K3),
		// innovation
		m(V_H0, V_XP0, SH_12, V_ZERO, 1'b0, 1'b0, V_HX),
		m(V_H1, V_XP1, SH_12, V_NONE, 1'b0, 1'b1, V_HX),
		m(V_Z0, V_ONE, SH_0, V_ZERO, 1'b0, 1'b0, V_E0),
		m(V_HX, V_ONE, SH_0, V_NONE, 1'b1, 1'b1, V_E0),
		m(V_H2, V_XP0, SH_12, V_ZERO, 1'b0, 1'b0, V_HX),
		m(V_H3, V_XP1, SH_12, V_NONE, 1'b0, 1'b1, V_HX),
		m(V_Z1, V_ONE, SH_0, V_ZERO, 1'b0, 1'b0, V_E1),
		m(V_HX, V_ONE, SH_0, V_NONE, 1'b1, 1'b1, V_E1),
		// state update
		m(V_XP0, V_ONE, SH_0, V_ZERO, 1'b0, 1'b0, V_X0),
		m(V_K0, V_E0, SH_16, V_NONE, 1'b0, 1'b0, V_X0),
		m(V_K1, V_E1, SH_16, V_NONE, 1'b0, 1'b1, V_X0),
		m(V_XP1, V_ONE, SH_0, V_ZERO, 1'b0, 1'b0, V_X1),
		m(V_K2, V_E0, SH_16, V_NONE, 1'b0, 1'b0, V_X1),
		m(V_K3, V_E1, SH_16, V_NONE, 1'b0, 1'b1, V_X1),
		// I - K H
		m(V_K0, V_H0, SH_12, V_ONEX, 1'b1, 1'b0, V_G0),
		m(V_K1, V_H2, SH_12, V_NONE, 1'b1, 1'b1, V_G0),
		m(V_K0, V_H1, SH_12, V_ZERO, 1'b1, 1'b0, V_G1),
		m(V_K1, V_H3, SH_12, V_NONE, 1'b1, 1'b1, V_G1),
		m(V_K2, V_H0, SH_12, V_ZERO, 1'b1, 1'b0, V_G2),
		m(V_K3, V_H2, SH_12, V_NONE, 1'b1, 1'b1, V_G2),
		m(V_K2, V_H1, SH_12, V_ONEX, 1'b1, 1'b0, V_G3),
		m(V_K3, V_H3, SH_12, V_NONE, 1'b1, 1'b1, V_G3),
		// covariance update
		m(V_G0, V_PP0, SH_16, V_ZERO, 1'b0, 1'b0, V_P0),
		m(V_G1, V_PP2, SH_16, V_NONE, 1'b0, 1'b1, V_P0),
		m(V_G0, V_PP1, SH_16, V_ZERO, 1'b0, 1'b0, V_P1),
		m(V_G1, V_PP3, SH_16, V_NONE, 1'b0, 1'b1, V_P1),
		m(V_G2, V_PP0, SH_16, V_ZERO, 1'b0, 1'b0, V_P2),
		m(V_G3, V_PP2, SH_16, V_NONE, 1'b0, 1'b1, V_P2),
		m(V_G2, V_PP1, SH_16, V_ZERO, 1'b0, 1'b0, V_P3),
		m(V_G3, V_PP3, SH_16, V_NONE, 1'b0, 1'b1, V_P3),
		fin(),
		// singular: keep the prediction
		m(V_XP0, V_ONE, SH_0, V_ZERO, 1'b0, 1'b1, V_X0),
		m(V_XP1, V_ONE, SH_0, V_ZERO, 1'b0, 1'b1, V_X1),
		m(V_PP0, V_ONE, SH_0, V_ZERO, 1'b0, 1'b1, V_P0),
		m(V_PP1, V_ONE, SH_0, V_ZERO, 1'b0, 1'b1, V_P1),
		m(V_PP2, V_ONE, SH_0, V_ZERO, 1'b0, 1'b1, V_P2),
		m(V_PP3, V_ONE, SH_0, V_ZERO, 1'b0, 1'b1, V_P3),
		fin()
	};

endpackage
`default_nettype wire

// File: rtl/two_state_kalman_filter.sv
// Top level of the two-state Kalman filter: microcoded sequencer, register
// file memory, shared multiply-accumulate unit and shift-subtract divider.
// Depends on tskf_pkg.
//
// One item at a time. The first item after reset runs the short first-item
// program. A normal item runs 86 multiply-accumulate steps on the single
// 32x32 multiplier, each an operand read, a multiply and a round/accumulate,
// plus four gain divisions in the restoring divider. A singular item ends
// early and keeps the prediction. in_ready is high only while the block is
// idle; a finished estimate waits in the output register, and the next item
// is accepted while it waits.
`default_nettype none
module two_state_kalman_filter (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic signed [31:0] meas_position,
	input wire logic signed [31:0] meas_velocity,
	input wire logic signed [31:0] control_accel,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [31:0] est_position,
	output logic signed [31:0] est_velocity,
	output logic singular,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [63:0] cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN = 3'b010,
		S_DIV = 3'b100
	} state_t;

	state_t state_q;
	logic [1:0] ph_q;
	logic [6:0] pc_q;
	logic first_q, sing_q;
	logic [63:0] a_q, h_q, q_q, r_q;
	logic [31:0] b_q;
	logic signed [31:0] z0_q, z1_q, u_q;

	logic signed [31:0] rf [tskf_pkg::RF_DEPTH];
	logic signed [31:0] ra_q, rb_q, ca_q, cb_q;
	logic amem_q, bmem_q;
	logic signed [63:0] prod_q;
	logic signed [65:0] acc_q, det_q, num_q;

	logic [65:0] dun_q, dud_q, drem_q;
	logic [30:0] dd_q, dquo_q;
	logic [4:0] dcnt_q;
	logic dneg_q;

	tskf_pkg::uinst_t ui;
	logic signed [31:0] opa_v, opb_v, mul_a, mul_b;
	logic signed [65:0] prod_x, term, base, acc_new, ini_v;
	logic we;
	logic signed [31:0] wdata;
	logic [65:0] un, ud, dt, dr_next;
	logic dge, ovf, sneg;
	logic [30:0] dq_next;
	logic emit;

	function automatic logic signed [31:0] cval(input tskf_pkg::opnd_t c,
		input logic [63:0] am, input logic [31:0] bv, input logic [63:0] hm,
		input logic [63:0] qm, input logic [63:0] rm, input logic signed [31:0] z0,
		input logic signed [31:0] z1, input logic signed [31:0] u);
		logic signed [31:0] v;
		v = '0;
		case (c) inside
			tskf_pkg::V_Z0: v = z0;
			tskf_pkg::V_Z1: v = z1;
			tskf_pkg::V_U: v = u;
			tskf_pkg::V_A0, tskf_pkg::V_A1, tskf_pkg::V_A2, tskf_pkg::V_A3:
				v = tskf_pkg::ent(am, c[1:0] - 2'd2);
			tskf_pkg::V_B0, tskf_pkg::V_B1: v = tskf_pkg::ent({32'd0, bv}, {1'b0, c[0]});
			tskf_pkg::V_H0, tskf_pkg::V_H1, tskf_pkg::V_H2, tskf_pkg::V_H3:
				v = tskf_pkg::ent(hm, c[1:0]);
			tskf_pkg::V_Q0, tskf_pkg::V_Q1, tskf_pkg::V_Q2, tskf_pkg::V_Q3:
				v = tskf_pkg::ent(qm, c[1:0]);
			tskf_pkg::V_R0, tskf_pkg::V_R1, tskf_pkg::V_R2, tskf_pkg::V_R3:
				v = tskf_pkg::ent(rm, c[1:0]);
			tskf_pkg::V_ONE: v = 32'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

	assign ui = tskf_pkg::UCODE[pc_q];
	assign in_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign emit = state_q == S_RUN && ui.op == tskf_pkg::U_END && ph_q == 2'd1 &&
		(!out_valid || out_ready);

	always_comb begin
		opa_v = cval(ui.a, a_q, b_q, h_q, q_q, r_q, z0_q, z1_q, u_q);
		opb_v = cval(ui.b, a_q, b_q, h_q, q_q, r_q, z0_q, z1_q, u_q);
		mul_a = amem_q ? ra_q : ca_q;
		mul_b = bmem_q ? rb_q : cb_q;
	end

	always_comb begin
		ini_v = '0;
		case (ui.ini) inside
			tskf_pkg::V_Q0, tskf_pkg::V_Q1, tskf_pkg::V_Q2, tskf_pkg::V_Q3,
			tskf_pkg::V_R0, tskf_pkg::V_R1, tskf_pkg::V_R2, tskf_pkg::V_R3: begin
				ini_v = 66'(signed'(cval(ui.ini, a_q, b_q, h_q, q_q, r_q, z0_q, z1_q,
					u_q))) <<< 4;
			end
			tskf_pkg::V_ONEX: ini_v = 66'sd65536;
			default: ini_v = '0;
		endcase
		prod_x = 66'(prod_q);
		case (ui.sh)
			tskf_pkg::SH_12: term = (prod_x + 66'sd2048) >>> 12;
			tskf_pkg::SH_16: term = (prod_x + 66'sd32768) >>> 16;
			default: term = prod_x;
		endcase
		base = (ui.ini != tskf_pkg::V_NONE) ? ini_v : acc_q;
		acc_new = ui.sub ? base - term : base + term;
	end

	always_comb begin
		sneg = num_q[65] ^ det_q[65];
		un = num_q[65] ? 66'(-num_q) : 66'(num_q);
		ud = det_q[65] ? 66'(-det_q) : 66'(det_q);
		ovf = {15'd0, un} >= {ud, 15'd0};
		dt = {drem_q[64:0], dd_q[30]};
		dge = dt >= dud_q;
		dr_next = dge ? dt - dud_q : dt;
		dq_next = {dquo_q[29:0], dge};
	end

	always_comb begin
		we = 1'b0;
		wdata = '0;
		if (state_q == S_RUN && ph_q == 2'd2 && ui.op == tskf_pkg::U_MAC && ui.last &&
			ui.dst < 6'(tskf_pkg::RF_DEPTH)) begin
			we = 1'b1;
			wdata = tskf_pkg::sat32(acc_new);
		end else if (state_q == S_RUN && ph_q == 2'd0 && ui.op == tskf_pkg::U_DIV && ovf) begin
			we = 1'b1;
			wdata = sneg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else if (state_q == S_DIV && dcnt_q == 5'd0) begin
			we = 1'b1;
			wdata = dneg_q ? -signed'({1'b0, dq_next}) : signed'({1'b0, dq_next});
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			rf[ui.dst] <= wdata;
		end
		if (state_q == S_RUN && ph_q == 2'd0) begin
			ra_q <= rf[ui.a];
			rb_q <= rf[ui.b];
			ca_q <= opa_v;
			cb_q <= opb_v;
			amem_q <= ui.a < 6'(tskf_pkg::RF_DEPTH);
			bmem_q <= ui.b < 6'(tskf_pkg::RF_DEPTH);
		end
		if (state_q == S_RUN && ph_q == 2'd1) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == S_RUN && ph_q == 2'd2) begin
			acc_q <= acc_new;
			if (ui.last && ui.dst == tskf_pkg::DST_DET) begin
				det_q <= acc_new;
			end
			if (ui.last && ui.dst == tskf_pkg::DST_NUM) begin
				num_q <= acc_new;
			end
		end
		if (in_valid && in_ready) begin
			z0_q <= meas_position;
			z1_q <= meas_velocity;
			u_q <= control_accel;
		end
		if (state_q == S_RUN && ph_q == 2'd0 && ui.op == tskf_pkg::U_DIV) begin
			dun_q <= un;
			dud_q <= ud;
			dneg_q <= sneg;
			drem_q <= un >> 15;
			dd_q <= {un[14:0], 16'd0};
			dquo_q <= '0;
		end else if (state_q == S_DIV) begin
			drem_q <= dr_next;
			dd_q <= {dd_q[29:0], 1'b0};
			dquo_q <= dq_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= 64'h1000_0000_011F_1000;
			b_q <= 32'h011F_000A;
			h_q <= 64'h1000_0000_0000_1000;
			q_q <= 64'h0800_019A_019A_0E66;
			r_q <= 64'h0E66_0800_439A_D866;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tskf_pkg::REG_A: a_q <= cfg_data;
				tskf_pkg::REG_B: b_q <= cfg_data[31:0];
				tskf_pkg::REG_H: h_q <= cfg_data;
				tskf_pkg::REG_Q: q_q <= cfg_data;
				tskf_pkg::REG_R: r_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q <= 2'd0;
			pc_q <= tskf_pkg::PC_FIRST;
			first_q <= 1'b1;
			sing_q <= 1'b0;
			dcnt_q <= '0;
			out_valid <= 1'b0;
			est_position <= '0;
			est_velocity <= '0;
			singular <= 1'b0;
		end else begin
			if (emit) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						pc_q <= first_q ? tskf_pkg::PC_FIRST : tskf_pkg::PC_MAIN;
						first_q <= 1'b0;
						sing_q <= 1'b0;
						ph_q <= 2'd0;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					unique case (ui.op)
						tskf_pkg::U_MAC: begin
							if (ph_q == 2'd2) begin
								ph_q <= 2'd0;
								pc_q <= pc_q + 7'd1;
							end else begin
								ph_q <= ph_q + 2'd1;
							end
						end
						tskf_pkg::U_CHK: begin
							if (det_q == '0) begin
								sing_q <= 1'b1;
								pc_q <= tskf_pkg::PC_SING;
							end else begin
								pc_q <= pc_q + 7'd1;
							end
						end
						tskf_pkg::U_DIV: begin
							if (ovf) begin
								pc_q <= pc_q + 7'd1;
							end else begin
								dcnt_q <= 5'd30;
								state_q <= S_DIV;
							end
						end
						tskf_pkg::U_END: begin
							if (ph_q == 2'd0) begin
								ph_q <= 2'd1;
							end else if (emit) begin
								est_position <= ra_q;
								est_velocity <= rb_q;
								singular <= sing_q;
								ph_q <= 2'd0;
								state_q <= S_IDLE;
							end
						end
						default: ;
					endcase
				end
				S_DIV: begin
					dcnt_q <= dcnt_q - 5'd1;
					if (dcnt_q == 5'd0) begin
						pc_q <= pc_q + 7'd1;
						state_q <= S_RUN;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_RUN && ph_q == 2'd0 &&
		(pc_q == tskf_pkg::PC_FIRST || pc_q == tskf_pkg::PC_MAIN))
		else $error("item start did not enter the microprogram");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> drem_q < dud_q && dun_q >= drem_q - drem_q)
		else $error("divider remainder out of range");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_RUN && ui.op == tskf_pkg::U_END))
		else $error("result shown outside end of program");

endmodule
`default_nettype wire
